// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the curved slab mask RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked property, ignored while reset is high
`define CSVM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked property, checked during reset as well
`define CSVM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSVM_ASSERT(label, clk, rst, prop, msg)
`define CSVM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- rtl/core/csvm_pkg.sv -----
// ----------------------------------------------------------------------------
// csvm_pkg
// Types, constants and codes of the curved slab voxel mask.
// ----------------------------------------------------------------------------
package csvm_pkg;

  // volume limits and field widths
  localparam int MAX_ROWS    = 1024;
  localparam int MAX_SLICES  = 1024;
  localparam int VOXEL_BITS  = 16;
  localparam int ROW_W       = 10;
  localparam int POS_W       = 24;
  localparam int CROP_MARGIN = 2;

  // rounding divider: numerator 2*|pos|+s, denominator 2*s
  localparam int DIV_NUM_W = POS_W + 1;
  localparam int DIV_DEN_W = 17;

  // request codes
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_ROUTE  = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_VOXEL  = 2'd3
  } req_code_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_THICK_UP   = 3'd0,
    REG_THICK_DOWN = 3'd1,
    REG_MIN_VALUE  = 3'd2,
    REG_DIM_Y      = 3'd3,
    REG_DIM_Z      = 3'd4,
    REG_SPACING_Y  = 3'd5,
    REG_SPACING_Z  = 3'd6
  } cfg_reg_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOX,
    ST_RT_Y_GO,
    ST_RT_Y_WAIT,
    ST_RT_Z_GO,
    ST_RT_Z_WAIT,
    ST_FWD_RD,
    ST_FWD_USE,
    ST_BWD_RD,
    ST_BWD_USE,
    ST_CROP
  } csvm_state_t;

  // input request
  typedef struct packed {
    logic [1:0]                   req_type;
    logic signed [POS_W-1:0]      route_y;
    logic signed [POS_W-1:0]      route_z;
    logic [ROW_W-1:0]             voxel_row;
    logic [ROW_W-1:0]             voxel_slice;
    logic signed [VOXEL_BITS-1:0] voxel_value;
  } csvm_req_t;

  // result
  typedef struct packed {
    logic                         out_kind;
    logic signed [VOXEL_BITS-1:0] voxel_out;
    logic [ROW_W-1:0]             crop_low;
    logic [ROW_W-1:0]             crop_high;
  } csvm_rsp_t;

  // divider control and status
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/core/curved_slab_voxel_mask_top.sv -----
// ----------------------------------------------------------------------------
// curved_slab_voxel_mask_top
// Per-slice route row table with forward/backward fill, crop bounds and
// curved slab voxel masking.
// ----------------------------------------------------------------------------
//  channel | signals                     | direction
//  --------+-----------------------------+-----------------------------
//  in      | in_valid, in_ready, in_req  | requests: clear/route/finish/voxel
//  out     | out_valid, out_ready, out_rsp | masked voxel or crop bounds
//  cfg     | cfg_we, cfg_index, cfg_data | register writes, no read-back
//
//  voxel request: row table RAM registered read, then compare
//  route request: accept, then two 25-step passes of the shared divider, each
//  with a start state and a wait state that ends on divider done
//  finish request: accept, forward and, if dim_z > 1, backward fill sweep, crop result
//  clear request and reset: clearing pass over all MAX_SLICES table entries,
//  no request taken meanwhile; a full output register stalls the sequencer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module curved_slab_voxel_mask_top
  import csvm_pkg::*;
#(
  parameter int MAX_SLICES = csvm_pkg::MAX_SLICES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  csvm_req_t             in_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output csvm_rsp_t             out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_SLICES);
  localparam int DZ_W  = $clog2(MAX_SLICES + 1);
  localparam int CMP_W = (DZ_W > 11) ? DZ_W : 11;

  // configuration registers
  logic [ROW_W-1:0]             thickness_up;
  logic [ROW_W-1:0]             thickness_down;
  logic signed [VOXEL_BITS-1:0] min_value;
  logic [10:0]                  dim_y;
  logic [10:0]                  dim_z;
  logic [15:0]                  spacing_y;
  logic [15:0]                  spacing_z;

  // sequencer and datapath registers
  csvm_state_t      state, state_next;
  csvm_req_t        item;
  logic [IDX_W-1:0] idx;
  logic [ROW_W-1:0] prev;
  logic [ROW_W-1:0] row_min_seen;
  logic [ROW_W-1:0] row_max_seen;
  logic             y_ok;
  logic [ROW_W-1:0] y_row;

  // RAM and divider hookup
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ROW_W-1:0] ram_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic             accept;
  logic             out_free;
  logic             out_load;
  csvm_rsp_t        rsp_next;

  // effective volume size
  logic [10:0]       eff_dy;
  logic [CMP_W-1:0]  dz_wide;
  logic [CMP_W-1:0]  eff_dz;
  logic [IDX_W-1:0]  dz_m1;

  assign eff_dy  = (dim_y == 11'd0) ? 11'd1 :
                   (dim_y > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : dim_y;
  assign dz_wide = CMP_W'(dim_z);
  assign eff_dz  = (dz_wide == '0) ? CMP_W'(1) :
                   (dz_wide > CMP_W'(MAX_SLICES)) ? CMP_W'(MAX_SLICES) : dz_wide;
  assign dz_m1   = IDX_W'(eff_dz - CMP_W'(1));

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // divider operands: 2*|pos| + s over 2*s, zero spacing taken as one;
  // the y spacing stays selected for the whole y pass
  logic                 go_y;
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     pos_mag;
  logic [15:0]          sp_raw;
  logic [15:0]          sp;

  assign go_y    = (state == ST_RT_Y_GO) || (state == ST_RT_Y_WAIT);
  assign pos     = go_y ? item.route_y : item.route_z;
  assign pos_mag = pos[POS_W-1] ? (~pos + POS_W'(1)) : pos;
  assign sp_raw  = go_y ? spacing_y : spacing_z;
  assign sp      = (sp_raw == 16'd0) ? 16'd1 : sp_raw;

  // quotient range checks, a negative position only survives as zero
  logic q_zero;
  logic y_fits;
  logic z_fits;

  assign q_zero = (div_rsp.quotient == '0);
  assign y_fits = (!item.route_y[POS_W-1] || q_zero) &&
                  (div_rsp.quotient < DIV_NUM_W'(eff_dy));
  assign z_fits = (!item.route_z[POS_W-1] || q_zero) &&
                  (div_rsp.quotient < DIV_NUM_W'(eff_dz));

  // fill value for the forward and backward sweeps
  logic [ROW_W-1:0] fwd_fill;
  logic [ROW_W-1:0] bwd_fill;

  assign fwd_fill = (ram_rdata == '0 && idx != '0) ? prev : ram_rdata;
  assign bwd_fill = (ram_rdata == '0) ? prev : ram_rdata;

  // slab window check for a voxel
  logic [ROW_W-1:0] win_lo;
  logic [ROW_W:0]   win_sum;
  logic [10:0]      win_hi;
  logic [10:0]      dy_m1;
  logic             in_vol;
  logic             in_slab;

  assign dy_m1   = eff_dy - 11'd1;
  assign win_lo  = (ram_rdata >= thickness_up) ? (ram_rdata - thickness_up) : '0;
  assign win_sum = {1'b0, ram_rdata} + {1'b0, thickness_down};
  assign win_hi  = (win_sum > dy_m1) ? dy_m1 : win_sum;
  assign in_vol  = ({1'b0, item.voxel_row} < eff_dy) &&
                   (CMP_W'(item.voxel_slice) < eff_dz);
  assign in_slab = in_vol && (item.voxel_row >= win_lo) &&
                   ({1'b0, item.voxel_row} <= win_hi);

  // crop bounds from the seen row range
  logic [11:0] crop_sub;
  logic [11:0] crop_lo_w;
  logic [11:0] crop_add;
  logic [11:0] crop_hi_w;

  assign crop_sub  = 12'(thickness_up) + 12'(CROP_MARGIN);
  assign crop_lo_w = (12'(row_min_seen) >= crop_sub) ? (12'(row_min_seen) - crop_sub) : '0;
  assign crop_add  = 12'(row_max_seen) + 12'(thickness_down) + 12'(CROP_MARGIN);
  assign crop_hi_w = (crop_add > 12'(dy_m1)) ? 12'(dy_m1) : crop_add;

  // result formatting
  always_comb begin
    rsp_next = '0;
    if (state == ST_CROP) begin
      rsp_next.out_kind  = 1'b1;
      rsp_next.crop_low  = crop_lo_w[ROW_W-1:0];
      rsp_next.crop_high = crop_hi_w[ROW_W-1:0];
    end else begin
      rsp_next.voxel_out = in_slab ? item.voxel_value : min_value;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thickness_up   <= '0;
      thickness_down <= '0;
      min_value      <= '0;
      dim_y          <= 11'd1024;
      dim_z          <= 11'd1024;
      spacing_y      <= 16'd256;
      spacing_z      <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THICK_UP:   thickness_up   <= cfg_data[ROW_W-1:0];
        REG_THICK_DOWN: thickness_down <= cfg_data[ROW_W-1:0];
        REG_MIN_VALUE:  min_value      <= cfg_data[VOXEL_BITS-1:0];
        REG_DIM_Y:      dim_y          <= cfg_data[10:0];
        REG_DIM_Z:      dim_z          <= cfg_data[10:0];
        REG_SPACING_Y:  spacing_y      <= cfg_data;
        REG_SPACING_Z:  spacing_z      <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (idx == IDX_W'(MAX_SLICES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_req.req_type)
            REQ_CLEAR:  state_next = ST_CLEAR;
            REQ_ROUTE:  state_next = ST_RT_Y_GO;
            REQ_FINISH: state_next = ST_FWD_RD;
            REQ_VOXEL:  state_next = ST_VOX;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_VOX:       if (out_free) state_next = ST_IDLE;
      ST_RT_Y_GO:   state_next = ST_RT_Y_WAIT;
      ST_RT_Y_WAIT: if (div_rsp.done) state_next = ST_RT_Z_GO;
      ST_RT_Z_GO:   state_next = ST_RT_Z_WAIT;
      ST_RT_Z_WAIT: if (div_rsp.done) state_next = ST_IDLE;
      ST_FWD_RD:    state_next = ST_FWD_USE;
      ST_FWD_USE: begin
        if (idx == dz_m1) begin
          state_next = (dz_m1 == '0) ? ST_CROP : ST_BWD_RD;
        end else begin
          state_next = ST_FWD_RD;
        end
      end
      ST_BWD_RD:    state_next = ST_BWD_USE;
      ST_BWD_USE:   state_next = (idx == '0) ? ST_CROP : ST_BWD_RD;
      ST_CROP:      if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: RAM ports, divider start, handshake
  always_comb begin
    in_ready          = 1'b0;
    out_load          = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = idx;
    ram_wdata         = '0;
    ram_raddr         = idx;
    div_req.start     = 1'b0;
    div_req.dividend  = {pos_mag, 1'b0} + DIV_NUM_W'(sp);
    div_req.divisor   = {sp, 1'b0};
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = IDX_W'(in_req.voxel_slice);
      end
      ST_VOX: begin
        ram_raddr = IDX_W'(item.voxel_slice);
        out_load  = out_free;
      end
      ST_RT_Y_GO, ST_RT_Z_GO: begin
        div_req.start = 1'b1;
      end
      ST_RT_Z_WAIT: begin
        ram_we    = div_rsp.done && y_ok && z_fits;
        ram_waddr = div_rsp.quotient[IDX_W-1:0];
        ram_wdata = y_row;
      end
      ST_FWD_USE: begin
        ram_we    = (ram_rdata == '0) && (idx != '0);
        ram_wdata = prev;
      end
      ST_BWD_USE: begin
        ram_we    = (ram_rdata == '0);
        ram_wdata = prev;
      end
      ST_CROP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      idx          <= '0;
      row_min_seen <= '0;
      row_max_seen <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          idx <= idx + IDX_W'(1);
        end
        ST_IDLE: begin
          idx <= '0;
          if (accept && in_req.req_type == REQ_CLEAR) begin
            row_min_seen <= '0;
            row_max_seen <= '0;
          end
        end
        ST_FWD_USE: begin
          if (idx == dz_m1) begin
            row_min_seen <= fwd_fill;
            row_max_seen <= fwd_fill;
            idx          <= dz_m1 - IDX_W'(1);
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_BWD_USE: begin
          if (bwd_fill < row_min_seen) row_min_seen <= bwd_fill;
          if (bwd_fill > row_max_seen) row_max_seen <= bwd_fill;
          idx <= idx - IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_req;
    end
    if (state == ST_RT_Y_WAIT && div_rsp.done) begin
      y_ok  <= y_fits;
      y_row <= div_rsp.quotient[ROW_W-1:0];
    end
    if (state == ST_FWD_USE) begin
      prev <= fwd_fill;
    end
    if (state == ST_BWD_USE) begin
      prev <= bwd_fill;
    end
    if (out_load) begin
      out_rsp <= rsp_next;
    end
  end

  csvm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SLICES)
  ) u_row_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  csvm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  `CSVM_ASSERT(a_voxel_to_vox, clk, rst, accept && in_req.req_type == REQ_VOXEL |=> state == ST_VOX, "voxel request did not enter compare")
  `CSVM_ASSERT(a_no_overwrite, clk, rst, out_valid && !out_ready |-> !out_load, "pending result overwritten")
  `CSVM_ASSERT(a_div_done_waiting, clk, rst, div_rsp.done |-> (state == ST_RT_Y_WAIT || state == ST_RT_Z_WAIT), "divider result not awaited")
  `CSVM_ASSERT(a_ram_write_state, clk, rst, ram_we |-> (state == ST_CLEAR || state == ST_RT_Z_WAIT || state == ST_FWD_USE || state == ST_BWD_USE), "row table written outside a write state")

endmodule

// ----- rtl/core/csvm_ram.sv -----
// ----------------------------------------------------------------------------
// csvm_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module csvm_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/csvm_div.sv -----
// ----------------------------------------------------------------------------
// csvm_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csvm_div
  import csvm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t div_req,
  output div_rsp_t div_rsp
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_NUM_W-1:0] quo;

  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;
  logic [DIV_DEN_W:0]   rem_sub;

  // shift in next dividend bit and trial subtract
  assign rem_sh  = {rem, quo[DIV_NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, div_req.divisor};
  assign rem_sub = rem_sh - {1'b0, div_req.divisor};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (div_req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits replace dividend bits
  always_ff @(posedge clk) begin
    if (div_req.start) begin
      rem <= '0;
      quo <= div_req.dividend;
    end else if (busy) begin
      rem <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

  assign div_rsp.done     = done;
  assign div_rsp.quotient = quo;

  `CSVM_ASSERT(a_div_no_restart, clk, rst, div_req.start |-> !busy, "divider restarted while busy")
  `CSVM_ASSERT(a_div_done_after_busy, clk, rst, done |-> $past(busy), "divider done without run")

endmodule
